>>> sv/tfst_pkg.sv
// shared types, frame codes and plausibility limits for the frame sequence tracker
`timescale 1ns / 1ps
`default_nettype none

package tfst_pkg;

  localparam logic [10:0] IdStatus   = 11'h002;
  localparam logic [10:0] IdInjector = 11'h004;
  localparam logic [10:0] IdSpeed    = 11'h005;

  localparam logic [15:0] TimeoutReset = 16'd500;
  localparam logic [16:0] MarginMs     = 17'd200;
  localparam logic [26:0] InjUsPerMs   = 27'd1000;
  localparam logic [26:0] InjCapUs     = 27'd5000000;
  localparam logic [17:0] SpdCap       = 18'd10000;

  typedef enum logic [1:0] {
    KindIgnored  = 2'd0,
    KindStatus   = 2'd1,
    KindInjector = 2'd2,
    KindSpeed    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [63:0] payload;
    logic [31:0] now_ms;
  } frame_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] raw_value;
    logic [15:0] speed_period;
    logic [15:0] engine_rpm;
    logic        injector_cut;
    logic        oil_low;
    logic [15:0] lost_status;
    logic [15:0] lost_injector;
    logic [15:0] lost_speed;
    logic [31:0] inj_time_total;
    logic [31:0] inj_pulse_total;
    logic [31:0] speed_pulse_total;
  } result_t;

  typedef struct packed {
    logic [7:0]  status_seq;
    logic [7:0]  injector_seq;
    logic [7:0]  speed_seq;
    logic        status_synced;
    logic        injector_synced;
    logic        speed_synced;
    logic [31:0] status_time;
    logic [31:0] injector_time;
    logic [31:0] speed_time;
    logic [31:0] injector_time_ref;
    logic [15:0] injector_pulse_ref;
    logic [31:0] speed_pulse_ref;
    logic [15:0] lost_status;
    logic [15:0] lost_injector;
    logic [15:0] lost_speed;
    logic [31:0] inj_time_sum;
    logic [31:0] inj_pulse_sum;
    logic [31:0] speed_pulse_sum;
    logic [15:0] latest_raw;
    logic [15:0] latest_speed_period;
    logic [15:0] latest_rpm;
    logic        latest_cut;
    logic        latest_oil;
  } track_state_t;

  // add the number of skipped sequence numbers to a wrapping loss count
  function automatic logic [15:0] gap_add(logic [15:0] count, logic [7:0] rx,
                                          logic [7:0] last);
    logic [7:0] diff;
    diff = rx - (last + 8'd1);
    return count + {8'd0, diff};
  endfunction

endpackage

`default_nettype wire

>>> sv/tfst_stream_if.sv
// valid/ready channel carrying one payload item
`timescale 1ns / 1ps
`default_nettype none

interface tfst_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/tfst_tracker.sv
// sequence tracking state and its combinational update for one frame
`timescale 1ns / 1ps
`default_nettype none

module tfst_tracker (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire tfst_pkg::frame_t frame_i,
  input  wire logic [15:0]     timeout_i,
  output tfst_pkg::result_t    result_o
);

  tfst_pkg::track_state_t state_q, state_d;
  tfst_pkg::kind_e        kind;

  logic [31:0] now;
  logic [63:0] pl;
  logic [31:0] elapsed_st, elapsed_inj, elapsed_spd;

  logic [31:0] inj_t;
  logic [15:0] inj_pulses;
  logic [7:0]  inj_seq;
  logic [31:0] inj_dt;
  logic [15:0] inj_dp;
  logic [16:0] inj_e;
  logic [26:0] inj_cap_full;
  logic [26:0] inj_cap;

  logic [31:0] spd_cnt;
  logic [7:0]  spd_seq;
  logic [31:0] spd_d;
  logic [16:0] spd_e;
  logic [18:0] spd_cap3;
  logic [17:0] spd_cap_half;
  logic [17:0] spd_cap;

  assign now = frame_i.now_ms;
  assign pl  = frame_i.payload;

  assign elapsed_st  = now - state_q.status_time;
  assign elapsed_inj = now - state_q.injector_time;
  assign elapsed_spd = now - state_q.speed_time;

  assign inj_t      = pl[31:0];
  assign inj_pulses = pl[47:32];
  assign inj_seq    = pl[63:56];
  assign inj_dt     = inj_t - state_q.injector_time_ref;
  assign inj_dp     = inj_pulses - state_q.injector_pulse_ref;

  // only used once the timeout check passed, so elapsed fits in 16 bits
  assign inj_e        = {1'b0, elapsed_inj[15:0]} + tfst_pkg::MarginMs;
  assign inj_cap_full = {10'd0, inj_e} * tfst_pkg::InjUsPerMs;
  assign inj_cap      = (inj_cap_full > tfst_pkg::InjCapUs) ? tfst_pkg::InjCapUs
                                                             : inj_cap_full;

  assign spd_cnt      = pl[31:0];
  assign spd_seq      = pl[39:32];
  assign spd_d        = spd_cnt - state_q.speed_pulse_ref;
  assign spd_e        = {1'b0, elapsed_spd[15:0]} + tfst_pkg::MarginMs;
  assign spd_cap3     = {2'd0, spd_e} + {1'b0, spd_e, 1'b0};
  assign spd_cap_half = spd_cap3[18:1];
  assign spd_cap      = (spd_cap_half > tfst_pkg::SpdCap) ? tfst_pkg::SpdCap
                                                          : spd_cap_half;

  always_comb begin
    state_d = state_q;
    kind    = tfst_pkg::KindIgnored;
    case (frame_i.frame_id)
      tfst_pkg::IdStatus: begin
        kind = tfst_pkg::KindStatus;
        state_d.latest_raw          = pl[15:0];
        state_d.latest_speed_period = pl[31:16];
        state_d.latest_rpm          = pl[47:32];
        state_d.latest_cut          = pl[48];
        state_d.latest_oil          = pl[49];
        if (state_q.status_synced && (elapsed_st <= {16'd0, timeout_i})) begin
          state_d.lost_status = tfst_pkg::gap_add(state_q.lost_status, pl[63:56],
                                                  state_q.status_seq);
        end else begin
          state_d.status_synced = 1'b1;
        end
        state_d.status_seq  = pl[63:56];
        state_d.status_time = now;
      end
      tfst_pkg::IdInjector: begin
        kind = tfst_pkg::KindInjector;
        if (!state_q.injector_synced || (elapsed_inj > {16'd0, timeout_i})) begin
          state_d.injector_time_ref  = inj_t;
          state_d.injector_pulse_ref = inj_pulses;
          state_d.injector_seq       = inj_seq;
          state_d.injector_time      = now;
          state_d.injector_synced    = 1'b1;
        end else if (inj_seq != state_q.injector_seq) begin
          state_d.lost_injector = tfst_pkg::gap_add(state_q.lost_injector, inj_seq,
                                                    state_q.injector_seq);
          state_d.injector_seq       = inj_seq;
          state_d.injector_time      = now;
          state_d.injector_time_ref  = inj_t;
          state_d.injector_pulse_ref = inj_pulses;
          if (inj_dt <= {5'd0, inj_cap}) begin
            state_d.inj_time_sum  = state_q.inj_time_sum + inj_dt;
            state_d.inj_pulse_sum = state_q.inj_pulse_sum + {16'd0, inj_dp};
          end
        end
      end
      tfst_pkg::IdSpeed: begin
        kind = tfst_pkg::KindSpeed;
        if (!state_q.speed_synced || (elapsed_spd > {16'd0, timeout_i})) begin
          state_d.speed_pulse_ref = spd_cnt;
          state_d.speed_seq       = spd_seq;
          state_d.speed_time      = now;
          state_d.speed_synced    = 1'b1;
        end else if (spd_seq != state_q.speed_seq) begin
          state_d.lost_speed = tfst_pkg::gap_add(state_q.lost_speed, spd_seq,
                                                 state_q.speed_seq);
          state_d.speed_seq       = spd_seq;
          state_d.speed_time      = now;
          state_d.speed_pulse_ref = spd_cnt;
          if (spd_d <= {14'd0, spd_cap}) begin
            state_d.speed_pulse_sum = state_q.speed_pulse_sum + spd_d;
          end
        end
      end
      default: begin
        kind = tfst_pkg::KindIgnored;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    result_o.kind              = kind;
    result_o.raw_value         = state_d.latest_raw;
    result_o.speed_period      = state_d.latest_speed_period;
    result_o.engine_rpm        = state_d.latest_rpm;
    result_o.injector_cut      = state_d.latest_cut;
    result_o.oil_low           = state_d.latest_oil;
    result_o.lost_status       = state_d.lost_status;
    result_o.lost_injector     = state_d.lost_injector;
    result_o.lost_speed        = state_d.lost_speed;
    result_o.inj_time_total    = state_d.inj_time_sum;
    result_o.inj_pulse_total   = state_d.inj_pulse_sum;
    result_o.speed_pulse_total = state_d.speed_pulse_sum;
  end

endmodule

`default_nettype wire

>>> sv/telemetry_frame_sequence_tracker_core.sv
// top level: input register, tracker update, result register and timeout register
`timescale 1ns / 1ps
`default_nettype none

// Takes one received frame per cycle on frame_i and returns one result item per frame
// on result_o. The frame sits in an input register, the tracker state is updated in one
// pass of compares and adds (the injector cap uses one small constant multiply), and the
// result lands in an output register. While results are taken a new frame is taken
// every cycle; while a result waits, one more frame is held in the input register and
// frame_i then stalls. Every result shows the latest status fields, loss counts and sums
// after its frame.
// cfg_i writes timeout_ms (reset 500) and is always ready; write it only while idle.

module telemetry_frame_sequence_tracker_core (
  input wire logic clk_i,
  input wire logic rst_ni,
  tfst_stream_if.sink   frame_i,
  tfst_stream_if.source result_o,
  tfst_stream_if.sink   cfg_i
);

  logic              in_valid_q;
  tfst_pkg::frame_t  in_data_q;
  logic              out_valid_q;
  tfst_pkg::result_t out_data_q;
  tfst_pkg::result_t result_d;
  logic [15:0]       timeout_q;

  logic out_free;
  logic advance;
  logic in_accept;

  assign out_free  = !out_valid_q || result_o.ready;
  assign advance   = in_valid_q && out_free;
  assign in_accept = frame_i.valid && frame_i.ready;

  assign frame_i.ready = !in_valid_q || advance;
  assign cfg_i.ready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= frame_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= tfst_pkg::TimeoutReset;
    end else if (cfg_i.valid) begin
      timeout_q <= cfg_i.data;
    end
  end

  tfst_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .frame_i   (in_data_q),
    .timeout_i (timeout_q),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

endmodule

`default_nettype wire

>>> sv/tfst_checker.sv
// port-level checks for the frame sequence tracker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module tfst_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire tfst_pkg::result_t out_data_i
);

  logic              seen_q;
  tfst_pkg::result_t prev_q;
  logic              out_accept;

  assign out_accept = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (out_accept) begin
      seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_accept) begin
      prev_q <= out_data_i;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // a fresh result comes from an item that was accepted at the input and passed the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching item");

  // status words and status losses move only on status items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_accept && seen_q && (out_data_i.kind != tfst_pkg::KindStatus) |->
      (out_data_i.lost_status == prev_q.lost_status) &&
      (out_data_i.raw_value == prev_q.raw_value))
    else $error("status state changed on a non-status item");

  // injector losses and the injector time sum move only on injector items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_accept && seen_q && (out_data_i.kind != tfst_pkg::KindInjector) |->
      (out_data_i.lost_injector == prev_q.lost_injector) &&
      (out_data_i.inj_time_total == prev_q.inj_time_total))
    else $error("injector state changed on a non-injector item");

endmodule

bind telemetry_frame_sequence_tracker_core tfst_checker u_tfst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (frame_i.valid),
  .in_ready_i  (frame_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);

`default_nettype wire

>>> sim/testbench.sv
// self-checking testbench for the telemetry frame sequence tracker core
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned LongHold  = 300;

  typedef enum logic [1:0] {
    RxOpen,
    RxCoin,
    RxPeriodic,
    RxSparse
  } rx_mode_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic              frame_valid  = 1'b0;
  tfst_pkg::frame_t  frame_data   = '0;
  logic              result_ready = 1'b0;
  logic              cfg_valid    = 1'b0;
  logic [15:0]       cfg_data     = '0;

  tfst_stream_if #(.data_t(tfst_pkg::frame_t))  frame_if ();
  tfst_stream_if #(.data_t(tfst_pkg::result_t)) result_if ();
  tfst_stream_if #(.data_t(logic [15:0]))       cfg_if ();

  assign frame_if.valid  = frame_valid;
  assign frame_if.data   = frame_data;
  assign result_if.ready = result_ready;
  assign cfg_if.valid    = cfg_valid;
  assign cfg_if.data     = cfg_data;

  telemetry_frame_sequence_tracker_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // frames waiting for the driver and results waiting for the dut
  tfst_pkg::frame_t  pending_frames[$];
  tfst_pkg::result_t predicted_results[$];
  int unsigned frames_issued   = 0;
  int unsigned frames_accepted = 0;
  int unsigned mismatches      = 0;
  int unsigned idle_cycles     = 0;
  int unsigned hold_trigger    = 0;

  // tracker state as the predictor sees it
  logic [15:0] timeout_reg = tfst_pkg::TimeoutReset;
  logic [7:0]  sts_seq = '0, inj_seq = '0, spd_seq = '0;
  logic        sts_sync = 1'b0, inj_sync = 1'b0, spd_sync = 1'b0;
  logic [31:0] sts_ms = '0, inj_ms = '0, spd_ms = '0;
  logic [31:0] inj_t_ref = '0, spd_ref = '0;
  logic [15:0] inj_p_ref = '0;
  logic [15:0] lost_sts = '0, lost_inj = '0, lost_spd = '0;
  logic [31:0] inj_t_sum = '0, inj_p_sum = '0, spd_sum = '0;
  logic [15:0] raw_word = '0, period_word = '0, rpm_word = '0;
  logic        cut_flag = 1'b0, oil_flag = 1'b0;

  // stimulus generator state
  logic [31:0] gen_now;
  logic [7:0]  g_sts_seq, g_inj_seq, g_spd_seq;
  logic [31:0] g_inj_t, g_spd_cnt, g_inj_ms, g_spd_ms;
  logic [15:0] g_inj_p;

  function automatic logic [15:0] add_missed(logic [15:0] lost, logic [7:0] rx,
                                             logic [7:0] prev);
    logic [7:0] missed;
    missed = rx - prev - 8'd1;
    return lost + {8'd0, missed};
  endfunction

  function automatic tfst_pkg::result_t track_frame(tfst_pkg::frame_t fr);
    tfst_pkg::result_t res;
    tfst_pkg::kind_e   kind;
    logic [31:0] elapsed, delta_t, delta_cnt;
    logic [15:0] delta_p;
    logic [63:0] limit;
    logic [7:0]  seq;
    kind = tfst_pkg::KindIgnored;
    case (fr.frame_id)
      tfst_pkg::IdStatus: begin
        kind        = tfst_pkg::KindStatus;
        seq         = fr.payload[63:56];
        raw_word    = fr.payload[15:0];
        period_word = fr.payload[31:16];
        rpm_word    = fr.payload[47:32];
        cut_flag    = fr.payload[48];
        oil_flag    = fr.payload[49];
        elapsed     = fr.now_ms - sts_ms;
        if (sts_sync && elapsed <= {16'd0, timeout_reg}) begin
          lost_sts = add_missed(lost_sts, seq, sts_seq);
        end else begin
          sts_sync = 1'b1;
        end
        sts_seq = seq;
        sts_ms  = fr.now_ms;
      end
      tfst_pkg::IdInjector: begin
        kind    = tfst_pkg::KindInjector;
        seq     = fr.payload[63:56];
        elapsed = fr.now_ms - inj_ms;
        if (!inj_sync || elapsed > {16'd0, timeout_reg}) begin
          inj_t_ref = fr.payload[31:0];
          inj_p_ref = fr.payload[47:32];
          inj_seq   = seq;
          inj_ms    = fr.now_ms;
          inj_sync  = 1'b1;
        end else if (seq != inj_seq) begin
          lost_inj  = add_missed(lost_inj, seq, inj_seq);
          inj_seq   = seq;
          delta_t   = fr.payload[31:0] - inj_t_ref;
          delta_p   = fr.payload[47:32] - inj_p_ref;
          inj_ms    = fr.now_ms;
          inj_t_ref = fr.payload[31:0];
          inj_p_ref = fr.payload[47:32];
          limit = (64'(elapsed) + 64'(tfst_pkg::MarginMs)) * 64'(tfst_pkg::InjUsPerMs);
          if (limit > 64'(tfst_pkg::InjCapUs)) limit = 64'(tfst_pkg::InjCapUs);
          if (64'(delta_t) <= limit) begin
            inj_t_sum = inj_t_sum + delta_t;
            inj_p_sum = inj_p_sum + {16'd0, delta_p};
          end
        end
      end
      tfst_pkg::IdSpeed: begin
        kind    = tfst_pkg::KindSpeed;
        seq     = fr.payload[39:32];
        elapsed = fr.now_ms - spd_ms;
        if (!spd_sync || elapsed > {16'd0, timeout_reg}) begin
          spd_ref  = fr.payload[31:0];
          spd_seq  = seq;
          spd_ms   = fr.now_ms;
          spd_sync = 1'b1;
        end else if (seq != spd_seq) begin
          lost_spd  = add_missed(lost_spd, seq, spd_seq);
          spd_seq   = seq;
          delta_cnt = fr.payload[31:0] - spd_ref;
          spd_ms    = fr.now_ms;
          spd_ref   = fr.payload[31:0];
          limit = ((64'(elapsed) + 64'(tfst_pkg::MarginMs)) * 64'd3) / 64'd2;
          if (limit > 64'(tfst_pkg::SpdCap)) limit = 64'(tfst_pkg::SpdCap);
          if (64'(delta_cnt) <= limit) spd_sum = spd_sum + delta_cnt;
        end
      end
      default: ;
    endcase
    res.kind              = kind;
    res.raw_value         = raw_word;
    res.speed_period      = period_word;
    res.engine_rpm        = rpm_word;
    res.injector_cut      = cut_flag;
    res.oil_low           = oil_flag;
    res.lost_status       = lost_sts;
    res.lost_injector     = lost_inj;
    res.lost_speed        = lost_spd;
    res.inj_time_total    = inj_t_sum;
    res.inj_pulse_total   = inj_p_sum;
    res.speed_pulse_total = spd_sum;
    return res;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", label, want, got);
    end
  endtask

  // driver: bursts of frames with random gaps in between
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      frame_valid <= 1'b0;
    end else if (!frame_valid || frame_if.ready) begin
      if (gap_left > 0 || pending_frames.size() == 0) begin
        if (gap_left > 0) gap_left--;
        frame_valid <= 1'b0;
      end else begin
        frame_valid <= 1'b1;
        frame_data  <= pending_frames.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // receiver: stall pattern that changes now and then, plus long hold-offs on request
  rx_mode_e    rx_mode   = RxOpen;
  int unsigned mode_left = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_cycle  = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = LongHold;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RxOpen:     result_ready <= 1'b1;
          RxCoin:     result_ready <= 1'($urandom_range(0, 1));
          RxPeriodic: result_ready <= (rx_cycle % 4) != 0;
          default:    result_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor: predict on accepted frames, compare on accepted results
  always @(posedge clk_i) begin : monitor
    tfst_pkg::result_t got, want;
    logic              moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (result_if.valid && result_if.ready) begin
        moved = 1'b1;
        got   = result_if.data;
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result item with none expected: %h", got);
        end else begin
          want = predicted_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("raw_value", 32'(want.raw_value), 32'(got.raw_value));
          check_field("speed_period", 32'(want.speed_period), 32'(got.speed_period));
          check_field("engine_rpm", 32'(want.engine_rpm), 32'(got.engine_rpm));
          check_field("injector_cut", 32'(want.injector_cut), 32'(got.injector_cut));
          check_field("oil_low", 32'(want.oil_low), 32'(got.oil_low));
          check_field("lost_status", 32'(want.lost_status), 32'(got.lost_status));
          check_field("lost_injector", 32'(want.lost_injector), 32'(got.lost_injector));
          check_field("lost_speed", 32'(want.lost_speed), 32'(got.lost_speed));
          check_field("inj_time_total", want.inj_time_total, got.inj_time_total);
          check_field("inj_pulse_total", want.inj_pulse_total, got.inj_pulse_total);
          check_field("speed_pulse_total", want.speed_pulse_total,
                      got.speed_pulse_total);
        end
      end
      if (frame_if.valid && frame_if.ready) begin
        moved = 1'b1;
        predicted_results.push_back(track_frame(frame_if.data));
        frames_accepted++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved       = 1'b1;
        timeout_reg = cfg_if.data;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    do @(negedge clk_i); while (idle_cycles < IdleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic queue_frame(input logic [10:0] id, input logic [63:0] payload,
                             input logic [31:0] now);
    tfst_pkg::frame_t fr;
    fr.frame_id = id;
    fr.payload  = payload;
    fr.now_ms   = now;
    pending_frames.push_back(fr);
    frames_issued++;
  endtask

  function automatic logic [63:0] status_word(logic [15:0] raw, logic [15:0] period,
                                              logic [15:0] rpm, logic [7:0] flags,
                                              logic [7:0] seq);
    return {seq, flags, rpm, period, raw};
  endfunction

  function automatic logic [63:0] inj_word(logic [31:0] open_us, logic [15:0] pulses,
                                           logic [7:0] seq);
    return {seq, 8'($urandom), pulses, open_us};
  endfunction

  function automatic logic [63:0] spd_word(logic [31:0] cnt, logic [7:0] seq);
    return {24'($urandom), seq, cnt};
  endfunction

  function automatic logic [7:0] next_seq(logic [7:0] prev, bit storm);
    int unsigned r;
    if (storm) return prev + 8'd1 + 8'($urandom_range(240, 254));
    r = $urandom_range(0, 19);
    if (r < 13) return prev + 8'd1;
    if (r < 16) return prev;
    if (r < 19) return prev + 8'd1 + 8'($urandom_range(1, 6));
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] time_step(int unsigned to, bit storm);
    int unsigned r;
    if (storm) return $urandom_range(0, to / 8);
    r = $urandom_range(0, 31);
    if (r < 20) return $urandom_range(0, to / 4);
    if (r < 26) return $urandom_range(0, to);
    if (r < 28) return 32'd0;
    if (r < 31) return to + $urandom_range(1, 3000);
    return $urandom;
  endfunction

  // counter delta around the plausibility cap: mostly inside, some on and past it
  function automatic logic [31:0] pick_delta(logic [31:0] cap);
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 11) return $urandom_range(0, cap);
    if (r == 11) return cap;
    if (r == 12) return cap + 32'd1;
    if (r == 13) return $urandom;
    if (r == 14) return 32'd0;
    return $urandom_range(cap + 1, 2 * cap + 1);
  endfunction

  task automatic queue_random(input int unsigned count, input bit storm,
                              input int unsigned to);
    tfst_pkg::kind_e sel;
    logic [63:0] cap;
    logic [31:0] e;
    logic [10:0] id;
    int unsigned r;
    for (int unsigned i = 0; i < count; i++) begin
      if (storm) begin
        sel = tfst_pkg::kind_e'(i % 3 + 1);
      end else begin
        r = $urandom_range(0, 15);
        sel = (r < 4) ? tfst_pkg::KindStatus :
              (r < 9) ? tfst_pkg::KindInjector :
              (r < 14) ? tfst_pkg::KindSpeed : tfst_pkg::KindIgnored;
      end
      gen_now = gen_now + time_step(to, storm);
      case (sel)
        tfst_pkg::KindStatus: begin
          g_sts_seq = next_seq(g_sts_seq, storm);
          queue_frame(tfst_pkg::IdStatus, {g_sts_seq, 8'($urandom), 16'($urandom),
                                           16'($urandom), 16'($urandom)}, gen_now);
        end
        tfst_pkg::KindInjector: begin
          e   = gen_now - g_inj_ms;
          cap = (64'(e) + 64'd200) * 64'd1000;
          if (cap > 64'd5000000) cap = 64'd5000000;
          g_inj_t   = g_inj_t + pick_delta(cap[31:0]);
          g_inj_p   = g_inj_p + 16'(($urandom_range(0, 3) == 0) ? $urandom
                                                                : $urandom_range(0, 40));
          g_inj_seq = next_seq(g_inj_seq, storm);
          g_inj_ms  = gen_now;
          queue_frame(tfst_pkg::IdInjector, inj_word(g_inj_t, g_inj_p, g_inj_seq),
                      gen_now);
        end
        tfst_pkg::KindSpeed: begin
          e   = gen_now - g_spd_ms;
          cap = ((64'(e) + 64'd200) * 64'd3) / 64'd2;
          if (cap > 64'd10000) cap = 64'd10000;
          g_spd_cnt = g_spd_cnt + pick_delta(cap[31:0]);
          g_spd_seq = next_seq(g_spd_seq, storm);
          g_spd_ms  = gen_now;
          queue_frame(tfst_pkg::IdSpeed, spd_word(g_spd_cnt, g_spd_seq), gen_now);
        end
        default: begin
          do id = 11'($urandom_range(0, 2047));
          while (id == tfst_pkg::IdStatus || id == tfst_pkg::IdInjector ||
                 id == tfst_pkg::IdSpeed);
          queue_frame(id, {$urandom, $urandom}, gen_now);
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (frames_accepted != frames_issued || predicted_results.size() != 0);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [31:0] t;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset timeout of 500 ms, times wrapping through zero
    t = 32'hFFFF_FE00;
    queue_frame(11'h000, '1, t);
    queue_frame(11'h7FF, '0, t);
    // status: first frame syncs, exactly at timeout keeps tracking, gap, repeat, resync
    queue_frame(tfst_pkg::IdStatus,
                status_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h10), t);
    queue_frame(tfst_pkg::IdStatus,
                status_word(16'h0, 16'h0, 16'h0, 8'h00, 8'h11), t + 500);
    queue_frame(tfst_pkg::IdStatus,
                status_word(16'h1234, 16'h5678, 16'h9ABC, 8'h01, 8'h15), t + 600);
    queue_frame(tfst_pkg::IdStatus,
                status_word(16'hA5A5, 16'h5A5A, 16'h0F0F, 8'h02, 8'h15), t + 601);
    queue_frame(tfst_pkg::IdStatus,
                status_word(16'h8001, 16'h7FFE, 16'h00FF, 8'hFE, 8'h40), t + 1102);
    // injector: sync, duplicate, delta on the cap, one past the cap, backwards, resync
    queue_frame(tfst_pkg::IdInjector, inj_word(32'd1000, 16'd10, 8'h00), t + 1200);
    queue_frame(tfst_pkg::IdInjector, inj_word(32'd5000, 16'd20, 8'h00), t + 1205);
    queue_frame(tfst_pkg::IdInjector, inj_word(32'd211000, 16'd30, 8'h01), t + 1210);
    queue_frame(tfst_pkg::IdInjector, inj_word(32'd416001, 16'd5, 8'h03), t + 1215);
    queue_frame(tfst_pkg::IdInjector, inj_word(32'd0, 16'hFFFF, 8'h04), t + 1300);
    queue_frame(tfst_pkg::IdInjector, inj_word(32'hFFFF_FFFF, 16'h0000, 8'hFF),
                t + 1801);
    queue_frame(tfst_pkg::IdInjector, inj_word(32'd99, 16'd1, 8'h00), t + 1801);
    // speed: sync, counter wrap on the cap, one past the cap, duplicate, gap, resync
    queue_frame(tfst_pkg::IdSpeed, spd_word(32'hFFFF_FFF0, 8'h00), t + 1900);
    queue_frame(tfst_pkg::IdSpeed, spd_word(32'h0000_011C, 8'h01), t + 1900);
    queue_frame(tfst_pkg::IdSpeed, spd_word(32'h0000_024A, 8'h02), t + 1901);
    queue_frame(tfst_pkg::IdSpeed, spd_word(32'h0000_0300, 8'h02), t + 1902);
    queue_frame(tfst_pkg::IdSpeed, spd_word(32'h0000_0377, 8'h00), t + 1902);
    queue_frame(tfst_pkg::IdSpeed, spd_word(32'h1234_5678, 8'h05), t + 2403);
    queue_frame(11'h003, {$urandom, $urandom}, t + 2403);
    queue_frame(11'h006, {$urandom, $urandom}, t + 2404);

    gen_now   = t + 3000;
    g_sts_seq = 8'h40;
    g_inj_seq = 8'h00;
    g_inj_t   = 32'd99;
    g_inj_p   = 16'd1;
    g_inj_ms  = t + 1801;
    g_spd_seq = 8'h05;
    g_spd_cnt = 32'h1234_5678;
    g_spd_ms  = t + 2403;
    queue_random(25, 1'b0, 500);
    wait_drained();

    // widest timeout; receiver holds off so the core backs up into its input
    write_timeout(16'hFFFF);
    hold_trigger++;
    queue_random(25, 1'b0, 65535);
    wait_drained();

    // zero timeout: any nonzero elapsed time resyncs
    write_timeout(16'd0);
    queue_random(10, 1'b0, 0);
    wait_drained();

    write_timeout(16'd1);
    queue_random(10, 1'b0, 1);
    wait_drained();

    begin
      logic [15:0] mid;
      mid = 16'($urandom_range(2, 65534));
      write_timeout(mid);
      gen_now = $urandom;
      queue_random(20, 1'b0, mid);
      wait_drained();
    end

    // long runs of large gaps so the loss counters wrap
    write_timeout(16'd40000);
    queue_random(810, 1'b1, 40000);
    wait_drained();

    write_timeout(16'd250);
    gen_now = $urandom;
    queue_random(10, 1'b0, 250);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> telemetry_frame_sequence_tracker_core.f
sv/tfst_pkg.sv
sv/tfst_stream_if.sv
sv/tfst_tracker.sv
sv/telemetry_frame_sequence_tracker_core.sv
sv/tfst_checker.sv
sim/testbench.sv
